// ===== hw/rtl/scf_pkg.sv =====
// Shared types, constants and helpers for the stereo chorus with feedback.
// Used by scf_lane, stereo_chorus_feedback and its checker; depends on nothing.
package scf_pkg;

	localparam int SAMPLE_BITS = 24;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef struct packed {
		sample_t left_in;
		sample_t right_in;
	} in_beat_t;

	typedef struct packed {
		sample_t left_out;
		sample_t right_out;
	} out_beat_t;

	typedef struct packed {
		logic [14:0]        dry_gain;
		logic signed [15:0] wet_gain;
		logic signed [15:0] feedback_gain;
		logic [17:0]        min_delay;
		logic [17:0]        delay_range;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_DRY_GAIN      = 3'd0,
		REG_WET_GAIN      = 3'd1,
		REG_FEEDBACK_GAIN = 3'd2,
		REG_MIN_DELAY     = 3'd3,
		REG_DELAY_RANGE   = 3'd4,
		REG_PHASE_STEP    = 3'd5,
		REG_STEREO_OFFSET = 3'd6,
		REG_NONE          = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SHAPE,
		ST_DELAY,
		ST_RD_A,
		ST_RD_B,
		ST_RD_P,
		ST_INTERP,
		ST_MIX,
		ST_OUT
	} state_t;

	typedef struct packed {
		state_t st;
		logic   wr_en;
	} ctl_t;

	localparam int WIDE_BITS = 41;

	// Clamp a wide signed value to the sample range.
	function automatic sample_t sat(input logic signed [WIDE_BITS-1:0] v);
		logic signed [WIDE_BITS-1:0] hi;
		logic signed [WIDE_BITS-1:0] lo;
		hi = WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
		lo = -hi - WIDE_BITS'(1);
		if (v > hi) begin
			sat = hi[SAMPLE_BITS-1:0];
		end else if (v < lo) begin
			sat = lo[SAMPLE_BITS-1:0];
		end else begin
			sat = v[SAMPLE_BITS-1:0];
		end
	endfunction

endpackage

// ===== hw/rtl/scf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scf_ram #(
	parameter int W = 24,
	parameter int D = 1024,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/scf_lane.sv =====
// One channel of the chorus: LFO shape, delay, two history RAMs, interpolation,
// feedback and output mix. Depends on scf_pkg and scf_ram.
module scf_lane #(
	parameter int BUF_DEPTH = 1024,
	localparam int AW = $clog2(BUF_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  scf_pkg::ctl_t     ctl,
	input  logic [AW-1:0]     pos,
	input  logic [AW:0]       fill,
	input  scf_pkg::cfg_t     cfg,
	input  logic [31:0]       phase,
	input  scf_pkg::sample_t  smp,
	output scf_pkg::sample_t  result
);

	localparam int DLW = (AW + 8 > 20) ? AW + 8 : 20;
	localparam logic [DLW-1:0] MAX_DL = DLW'((BUF_DEPTH - 3) * 256);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(BUF_DEPTH);

	function automatic logic [AW-1:0] back_idx(input logic [AW-1:0] p, input logic [AW:0] back);
		logic [AW:0] pw;
		logic [AW:0] r;
		pw = {1'b0, p};
		if (pw >= back) begin
			r = pw - back;
		end else begin
			r = pw + DEPTH_W - back;
		end
		back_idx = r[AW-1:0];
	endfunction

	function automatic scf_pkg::sample_t interp(input scf_pkg::sample_t a,
			input scf_pkg::sample_t b, input logic [7:0] f);
		logic signed [33:0] pa;
		logic signed [33:0] pb;
		logic signed [33:0] acc;
		pa = 34'(a * $signed({1'b0, 9'd256 - {1'b0, f}}));
		pb = 34'(b * $signed({2'b0, f}));
		acc = pa + pb;
		interp = acc[31:8];
	endfunction

	// LFO shape
	logic [15:0]        q;
	logic signed [18:0] t;
	logic signed [37:0] tt;
	logic [15:0]        sq_s1;
	logic               hi_s1;

	assign q = phase[31:16];
	assign t = q[15] ? $signed({1'b0, q, 2'b0}) - 19'sd196608
	                 : $signed({1'b0, q, 2'b0}) - 19'sd65536;
	assign tt = t * t;

	// Delay
	logic [16:0]    y;
	logic [34:0]    yr;
	logic [DLW-1:0] dl;
	logic [DLW-1:0] dlc;
	logic [AW-1:0]  d_s2;
	logic [7:0]     f_s2;

	assign y = hi_s1 ? {1'b0, sq_s1} : 17'd65536 - {1'b0, sq_s1};
	assign yr = y * cfg.delay_range;
	assign dl = DLW'(yr[34:16]) + DLW'(cfg.min_delay);
	assign dlc = (dl > MAX_DL) ? MAX_DL : dl;

	// Reads
	logic [AW-1:0] idx_a;
	logic [AW-1:0] idx_b;
	logic [AW-1:0] idx_p;
	logic [AW-1:0] raddr;
	logic          rvalid_q;
	scf_pkg::sample_t dry_rd;
	scf_pkg::sample_t wet_rd;
	scf_pkg::sample_t dry_m;
	scf_pkg::sample_t wet_m;

	assign idx_a = back_idx(pos, {1'b0, d_s2} + (AW+1)'(1));
	assign idx_b = back_idx(pos, {1'b0, d_s2} + (AW+1)'(2));
	assign idx_p = back_idx(pos, (AW+1)'(1));

	always_comb begin
		case (ctl.st)
			scf_pkg::ST_RD_A: raddr = idx_a;
			scf_pkg::ST_RD_B: raddr = idx_b;
			default:          raddr = idx_p;
		endcase
	end

	// Entries beyond the fill count were never written and read as zero.
	assign dry_m = rvalid_q ? dry_rd : '0;
	assign wet_m = rvalid_q ? wet_rd : '0;

	scf_pkg::sample_t wet_sum;

	scf_ram #(.W(scf_pkg::SAMPLE_BITS), .D(BUF_DEPTH)) u_dry (
		.clk(clk), .we(ctl.wr_en), .waddr(pos), .wdata(smp),
		.raddr(raddr), .rdata(dry_rd)
	);

	scf_ram #(.W(scf_pkg::SAMPLE_BITS), .D(BUF_DEPTH)) u_wet (
		.clk(clk), .we(ctl.wr_en), .waddr(pos), .wdata(wet_sum),
		.raddr(raddr), .rdata(wet_rd)
	);

	scf_pkg::sample_t a_dry_q, a_wet_q, b_dry_q, b_wet_q, prev_q;
	scf_pkg::sample_t idry_s3, iwet_s3, sum_s4;

	// Feedback and mix
	logic signed [39:0] fbp;
	logic signed [40:0] fsum;
	logic signed [39:0] wp;
	logic signed [39:0] dp;
	logic signed [40:0] macc;
	logic signed [40:0] mshift;

	assign fbp = iwet_s3 * cfg.feedback_gain;
	assign fsum = 41'(idry_s3) + 41'($signed(fbp[39:15]));
	assign wet_sum = scf_pkg::sat(fsum);

	assign wp = sum_s4 * cfg.wet_gain;
	assign dp = 40'($signed({1'b0, cfg.dry_gain}) * prev_q);
	assign macc = 41'(wp) + 41'(dp);
	assign mshift = macc >>> 15;
	assign result = scf_pkg::sat(mshift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else begin
			rvalid_q <= {1'b0, raddr} < fill;
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.st)
			scf_pkg::ST_SHAPE: begin
				sq_s1 <= tt[32:17];
				hi_s1 <= q[15];
			end
			scf_pkg::ST_DELAY: begin
				d_s2 <= dlc[AW+7:8];
				f_s2 <= dlc[7:0];
			end
			scf_pkg::ST_RD_B: begin
				a_dry_q <= dry_m;
				a_wet_q <= wet_m;
			end
			scf_pkg::ST_RD_P: begin
				b_dry_q <= dry_m;
				b_wet_q <= wet_m;
			end
			scf_pkg::ST_INTERP: begin
				prev_q  <= dry_m;
				idry_s3 <= interp(a_dry_q, b_dry_q, f_s2);
				iwet_s3 <= interp(a_wet_q, b_wet_q, f_s2);
			end
			scf_pkg::ST_MIX: begin
				sum_s4 <= wet_sum;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/stereo_chorus_feedback.sv =====
// Stereo chorus with feedback: top level with the register file, the LFO
// phase, the sequencer and the output register. Depends on scf_pkg and scf_lane.
//
// From acceptance, each stereo beat steps through shape, delay, the A, B and
// previous-sample reads, interpolation, mix and output before its result is
// in the output register: the left and right lanes run side by side, and
// each lane's history RAMs have one read port, so the two interpolation taps
// and the one-sample-old dry value are read one after another. A new beat is
// taken once the previous result has moved into the output register; a
// stalled output holds the lanes in their last step. Unwritten history reads
// as zero through a fill count, so no clearing pass follows reset.
module stereo_chorus_feedback #(
	parameter int BUF_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                audio_valid,
	output logic                audio_ready,
	input  scf_pkg::in_beat_t   audio,
	output logic                mix_valid,
	input  logic                mix_ready,
	output scf_pkg::out_beat_t  mix,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int AW = $clog2(BUF_DEPTH);

	scf_pkg::cfg_t  cfg_q;
	logic [31:0]    phase_step_q;
	logic [31:0]    stereo_offset_q;
	logic [31:0]    lfo_q;
	logic [AW-1:0]  pos_q;
	logic [AW:0]    fill_q;
	logic [31:0]    phl_q;
	logic [31:0]    phr_q;
	scf_pkg::in_beat_t  smp_q;
	scf_pkg::state_t    state_q;
	scf_pkg::state_t    state_d;
	scf_pkg::ctl_t      ctl;
	scf_pkg::reg_idx_t  ridx;
	scf_pkg::sample_t   res_l;
	scf_pkg::sample_t   res_r;
	logic               load;
	logic               wr;
	logic [31:0]        phl;

	assign pready = 1'b1;
	assign ridx = scf_pkg::reg_idx_t'(paddr[4:2]);
	assign wr = psel && penable && pwrite;

	always_comb begin
		case (ridx)
			scf_pkg::REG_DRY_GAIN:      prdata = 32'(cfg_q.dry_gain);
			scf_pkg::REG_WET_GAIN:      prdata = 32'(unsigned'(cfg_q.wet_gain));
			scf_pkg::REG_FEEDBACK_GAIN: prdata = 32'(unsigned'(cfg_q.feedback_gain));
			scf_pkg::REG_MIN_DELAY:     prdata = 32'(cfg_q.min_delay);
			scf_pkg::REG_DELAY_RANGE:   prdata = 32'(cfg_q.delay_range);
			scf_pkg::REG_PHASE_STEP:    prdata = phase_step_q;
			scf_pkg::REG_STEREO_OFFSET: prdata = stereo_offset_q;
			default:                    prdata = '0;
		endcase
	end

	// Next state
	always_comb begin
		case (state_q)
			scf_pkg::ST_IDLE:   state_d = audio_valid ? scf_pkg::ST_SHAPE : scf_pkg::ST_IDLE;
			scf_pkg::ST_SHAPE:  state_d = scf_pkg::ST_DELAY;
			scf_pkg::ST_DELAY:  state_d = scf_pkg::ST_RD_A;
			scf_pkg::ST_RD_A:   state_d = scf_pkg::ST_RD_B;
			scf_pkg::ST_RD_B:   state_d = scf_pkg::ST_RD_P;
			scf_pkg::ST_RD_P:   state_d = scf_pkg::ST_INTERP;
			scf_pkg::ST_INTERP: state_d = scf_pkg::ST_MIX;
			scf_pkg::ST_MIX:    state_d = scf_pkg::ST_OUT;
			scf_pkg::ST_OUT:    state_d = (!mix_valid || mix_ready) ? scf_pkg::ST_IDLE
			                                                        : scf_pkg::ST_OUT;
			default:            state_d = scf_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		audio_ready = (state_q == scf_pkg::ST_IDLE);
		ctl.st      = state_q;
		ctl.wr_en   = (state_q == scf_pkg::ST_MIX);
		load        = (state_q == scf_pkg::ST_OUT) && (!mix_valid || mix_ready);
	end

	assign phl = lfo_q + 32'h4000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= scf_pkg::ST_IDLE;
			cfg_q.dry_gain      <= 15'd16384;
			cfg_q.wet_gain      <= 16'sd16384;
			cfg_q.feedback_gain <= 16'sd0;
			cfg_q.min_delay     <= 18'd0;
			cfg_q.delay_range   <= 18'd122880;
			phase_step_q    <= 32'd89478;
			stereo_offset_q <= 32'h8000_0000;
			lfo_q           <= '0;
			pos_q           <= '0;
			fill_q          <= '0;
			mix_valid       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr) begin
				case (ridx)
					scf_pkg::REG_DRY_GAIN:      cfg_q.dry_gain      <= pwdata[14:0];
					scf_pkg::REG_WET_GAIN:      cfg_q.wet_gain      <= signed'(pwdata[15:0]);
					scf_pkg::REG_FEEDBACK_GAIN: cfg_q.feedback_gain <= signed'(pwdata[15:0]);
					scf_pkg::REG_MIN_DELAY:     cfg_q.min_delay     <= pwdata[17:0];
					scf_pkg::REG_DELAY_RANGE:   cfg_q.delay_range   <= pwdata[17:0];
					scf_pkg::REG_PHASE_STEP:    phase_step_q        <= pwdata;
					scf_pkg::REG_STEREO_OFFSET: stereo_offset_q     <= pwdata;
					default: begin
					end
				endcase
			end
			if (load) begin
				mix_valid <= 1'b1;
				lfo_q     <= lfo_q + phase_step_q;
				pos_q     <= (pos_q == AW'(BUF_DEPTH - 1)) ? '0 : pos_q + AW'(1);
				if (fill_q != (AW+1)'(BUF_DEPTH)) begin
					fill_q <= fill_q + (AW+1)'(1);
				end
			end else if (mix_ready) begin
				mix_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (audio_valid && audio_ready) begin
			smp_q <= audio;
			phl_q <= phl;
			phr_q <= phl + stereo_offset_q;
		end
		if (load) begin
			mix.left_out  <= res_l;
			mix.right_out <= res_r;
		end
	end

	scf_lane #(.BUF_DEPTH(BUF_DEPTH)) u_left (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pos(pos_q), .fill(fill_q),
		.cfg(cfg_q), .phase(phl_q), .smp(smp_q.left_in), .result(res_l)
	);

	scf_lane #(.BUF_DEPTH(BUF_DEPTH)) u_right (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .pos(pos_q), .fill(fill_q),
		.cfg(cfg_q), .phase(phr_q), .smp(smp_q.right_in), .result(res_r)
	);

endmodule

// ===== hw/rtl/scf_checker.sv =====
// Port-level checker for stereo_chorus_feedback and its bind statement.
// Depends on scf_pkg and the top level's ports.
module scf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                audio_valid,
	input logic                audio_ready,
	input logic                mix_valid,
	input logic                mix_ready,
	input scf_pkg::out_beat_t  mix,
	input logic                pready
);

	logic [1:0] pend_q;

	// Beats taken in but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(audio_valid && audio_ready) - 2'(mix_valid && mix_ready);
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		mix_valid |-> pend_q != 2'd0)
		else $error("result beat without a pending input beat");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(audio_valid && audio_ready) |=> !audio_ready)
		else $error("input taken while a beat is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && !mix_ready) |=> (mix_valid && $stable(mix)))
		else $error("stalled result beat changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind stereo_chorus_feedback scf_checker u_scf_checker (
	.clk(clk), .arst_n(arst_n), .audio_valid(audio_valid), .audio_ready(audio_ready),
	.mix_valid(mix_valid), .mix_ready(mix_ready), .mix(mix), .pready(pready)
);
